@@ design/psic_pkg.sv @@
// Shared types, constants and helpers for the polyline self-intersection check.
// Depends on nothing; every other file of the block but psic_if refers to it by scoped names.
`default_nettype none

package psic_pkg;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } vertex_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CROSS_TOL = 2'd0;
   localparam logic [1:0] CSR_COORD_TOL = 2'd1;

   localparam logic [31:0] CROSS_TOL_RESET = 32'd4295;
   localparam logic [15:0] COORD_TOL_RESET = 16'd0;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_OUTER,
      ST_GET_P,
      ST_GET_Q,
      ST_GET_R,
      ST_GET_S,
      ST_TEST,
      ST_RESULT
   } state_type;

   // Status returned by the pair tester.
   typedef struct packed {
      logic done;
      logic hit;
   } test_status_type;

   function automatic logic signed [31:0] smin(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [31:0] smax(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

@@ design/psic_if.sv @@
// Handshake interfaces for the vertex input, result output and register write channels.
// Depends on nothing; it does not refer to psic_pkg, and widths are fixed here.
`default_nettype none

interface psic_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic               last_point;
   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input last_point,
                 output ready);
endinterface

interface psic_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_simple;
   logic [7:0] first_segment;
   logic [7:0] second_segment;
   logic       overflow;
   modport source (output valid, output is_simple, output first_segment,
                   output second_segment, output overflow, input ready);
   modport sink (input valid, input is_simple, input first_segment,
                 input second_segment, input overflow, output ready);
endinterface

interface psic_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [31:0] write_data;
   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink (input valid, input reg_index, input write_data, output ready);
endinterface

`default_nettype wire

@@ design/psic_vstore.sv @@
// Vertex store: single-port-write, single-port-read synchronous memory with registered read data.
// Depends on psic_pkg for the vertex type.
`default_nettype none

module psic_vstore #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [AW-1:0]              wr_addr,
   input  psic_pkg::vertex_type      wr_data,
   input  wire                       rd_en,
   input  wire [AW-1:0]              rd_addr,
   output psic_pkg::vertex_type      rd_data
);

   psic_pkg::vertex_type mem [DEPTH];
   psic_pkg::vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/psic_pair_test.sv @@
// Segment pair tester: four cross products on one shared multiplier, then the decision.
// Depends on psic_pkg for the vertex type, the status struct and min/max helpers.
`default_nettype none

module psic_pair_test (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  psic_pkg::vertex_type         pt_p,
   input  psic_pkg::vertex_type         pt_q,
   input  psic_pkg::vertex_type         pt_r,
   input  psic_pkg::vertex_type         pt_s,
   input  wire [31:0]                   cross_tol,
   input  wire [15:0]                   coord_tol,
   output psic_pkg::test_status_type    status
);

   localparam logic [3:0] LAST_STEP = 4'd9;

   psic_pkg::vertex_type p_ff, q_ff, r_ff, s_ff;
   logic                 busy_ff, busy_in;
   logic [3:0]           step_ff, step_in;
   logic signed [65:0]   prod_ff, first_ff;
   logic [3:0]           pos_ff, neg_ff;

   psic_pkg::vertex_type va, vb, vc;
   logic signed [32:0]   op_a, op_b;
   logic signed [65:0]   prod_in;
   logic signed [66:0]   cross_val, tol_val;
   logic                 is_pos, is_neg;

   // Operand selection: step bits [2:1] pick the cross product, bit 0 its half.
   always_comb begin
      case (step_ff[2:1])
         2'd0: begin va = p_ff; vb = q_ff; vc = r_ff; end
         2'd1: begin va = p_ff; vb = q_ff; vc = s_ff; end
         2'd2: begin va = r_ff; vb = s_ff; vc = p_ff; end
         default: begin va = r_ff; vb = s_ff; vc = q_ff; end
      endcase
      if (!step_ff[0]) begin
         op_a = {vb.x[31], vb.x} - {va.x[31], va.x};
         op_b = {vc.y[31], vc.y} - {va.y[31], va.y};
      end else begin
         op_a = {vb.y[31], vb.y} - {va.y[31], va.y};
         op_b = {vc.x[31], vc.x} - {va.x[31], va.x};
      end
   end

   assign prod_in   = op_a * op_b;
   assign cross_val = {first_ff[65], first_ff} - {prod_ff[65], prod_ff};
   assign tol_val   = {35'd0, cross_tol};
   assign is_pos    = cross_val > tol_val;
   assign is_neg    = cross_val < -tol_val;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + 4'd1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // Product from step s-1 is handled at step s: odd steps keep the first half,
   // even steps from two to eight finish one cross product and record its orientation.
   always_ff @(posedge clock) begin
      if (start) begin
         p_ff <= pt_p;
         q_ff <= pt_q;
         r_ff <= pt_r;
         s_ff <= pt_s;
      end
      if (busy_ff) begin
         prod_ff <= prod_in;
         if (step_ff[0]) begin
            first_ff <= prod_ff;
         end else if (step_ff != 4'd0 && step_ff <= 4'd8) begin
            pos_ff[2'(step_ff[3:1] - 3'd1)] <= is_pos;
            neg_ff[2'(step_ff[3:1] - 3'd1)] <= is_neg;
         end
      end
   end

   // Final decision from the recorded signs and the coordinate ranges.
   logic signed [33:0] tol34;
   logic               meet_x, meet_y, on_r, on_s, on_p, on_q;
   logic [3:0]         zero_o;
   logic               split_pq, split_rs;

   function automatic logic meets(input logic signed [31:0] a0, input logic signed [31:0] a1,
                                  input logic signed [31:0] b0, input logic signed [31:0] b1,
                                  input logic signed [33:0] tol);
      logic signed [33:0] lo_v, hi_v;
      lo_v = 34'(psic_pkg::smax(psic_pkg::smin(a0, a1), psic_pkg::smin(b0, b1)));
      hi_v = 34'(psic_pkg::smin(psic_pkg::smax(a0, a1), psic_pkg::smax(b0, b1))) + tol;
      return lo_v <= hi_v;
   endfunction

   function automatic logic near(input psic_pkg::vertex_type pt,
                                 input psic_pkg::vertex_type sa,
                                 input psic_pkg::vertex_type sb,
                                 input logic signed [33:0] tol);
      logic signed [33:0] px, py;
      px = 34'(pt.x);
      py = 34'(pt.y);
      return px >= 34'(psic_pkg::smin(sa.x, sb.x)) - tol &&
             px <= 34'(psic_pkg::smax(sa.x, sb.x)) + tol &&
             py >= 34'(psic_pkg::smin(sa.y, sb.y)) - tol &&
             py <= 34'(psic_pkg::smax(sa.y, sb.y)) + tol;
   endfunction

   assign tol34    = {18'd0, coord_tol};
   assign meet_x   = meets(p_ff.x, q_ff.x, r_ff.x, s_ff.x, tol34);
   assign meet_y   = meets(p_ff.y, q_ff.y, r_ff.y, s_ff.y, tol34);
   assign zero_o   = ~(pos_ff | neg_ff);
   assign on_r     = zero_o[0] && near(r_ff, p_ff, q_ff, tol34);
   assign on_s     = zero_o[1] && near(s_ff, p_ff, q_ff, tol34);
   assign on_p     = zero_o[2] && near(p_ff, r_ff, s_ff, tol34);
   assign on_q     = zero_o[3] && near(q_ff, r_ff, s_ff, tol34);
   assign split_pq = (pos_ff[0] != pos_ff[1]) || (neg_ff[0] != neg_ff[1]);
   assign split_rs = (pos_ff[2] != pos_ff[3]) || (neg_ff[2] != neg_ff[3]);

   assign status.done = busy_ff && step_ff == LAST_STEP;
   assign status.hit  = meet_x && meet_y &&
                        (on_r || on_s || on_p || on_q || (split_pq && split_rs));

endmodule

`default_nettype wire

@@ design/polyline_self_intersection_check.sv @@
// Top level of the polyline self-intersection check: control sequencer and registers.
// Depends on psic_pkg, the interfaces in psic_if, psic_vstore and psic_pair_test.
//
// Usage: vertices arrive on the req channel, one transfer per cycle, each written
// into the vertex store. A transfer with last_point set ends the polyline and
// starts the check; the req channel then holds ready low until the result has
// been taken. Vertices beyond MAX_POINTS are dropped and reported as overflow.
// The check walks every pair of non-adjacent segments, earlier segment first,
// and stops at the first intersecting pair. Each pair takes a step to fetch its
// last vertex and start the pair tester, then the steps of the tester, whose
// shared multiplier forms eight products one after another. Starting a new
// earlier segment adds store reads of the four vertices of its first pair. With
// fewer than four stored vertices there is no pair and the result reports the
// polyline as simple.
// The single result sits in the rsp registers until the receiver takes it;
// a stalled receiver simply holds the block in that state. After the transfer
// the vertex count and overflow flag clear and a new polyline may start.
// Synchronous reset clears the control state and restores the register defaults;
// only entries written for the current polyline are read, so the store needs no
// clearing pass. The csr channel is always ready; writes belong to idle periods.

`default_nettype none

module polyline_self_intersection_check #(
   parameter int MAX_POINTS = 256
) (
   input wire        clock,
   input wire        reset,
   psic_req_if.sink   req_chan,
   psic_rsp_if.source rsp_chan,
   psic_csr_if.sink   csr_chan
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   psic_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff;
   logic          ovf_ff;
   logic [CW-1:0] i_ff, j_ff;
   logic [31:0]   cross_tol_ff;
   logic [15:0]   coord_tol_ff;
   logic          simple_ff;
   logic [7:0]    first_ff, second_ff;

   psic_pkg::vertex_type p_ff, q_ff, r_ff, s_ff;

   logic                      req_fire, rsp_fire, csr_fire;
   logic                      no_pair, more_j;
   logic                      rd_en;
   logic [CW-1:0]             rd_idx;
   logic                      test_start;
   psic_pkg::vertex_type      wr_vertex, rd_vertex;
   psic_pkg::test_status_type status;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;

   // No pair remains once the earlier segment has fewer than two segments after it.
   assign no_pair = ((CW+1)'(i_ff) + (CW+1)'(3)) >= (CW+1)'(count_ff);
   assign more_j  = ((CW+1)'(j_ff) + (CW+1)'(2)) <  (CW+1)'(count_ff);

   assign wr_vertex.x = req_chan.point_x;
   assign wr_vertex.y = req_chan.point_y;

   psic_vstore #(
      .DEPTH(MAX_POINTS),
      .AW   (AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (req_fire && count_ff < CW'(MAX_POINTS)),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(wr_vertex),
      .rd_en  (rd_en),
      .rd_addr(rd_idx[AW-1:0]),
      .rd_data(rd_vertex)
   );

   // The tester starts in the cycle in which the last vertex of the pair leaves
   // the store, so that vertex is taken straight from the read data.
   psic_pair_test u_test (
      .clock    (clock),
      .reset    (reset),
      .start    (test_start),
      .pt_p     (p_ff),
      .pt_q     (q_ff),
      .pt_r     (r_ff),
      .pt_s     (rd_vertex),
      .cross_tol(cross_tol_ff),
      .coord_tol(coord_tol_ff),
      .status   (status)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psic_pkg::ST_LOAD: begin
            if (req_fire && req_chan.last_point) state_in = psic_pkg::ST_OUTER;
         end
         psic_pkg::ST_OUTER: begin
            state_in = no_pair ? psic_pkg::ST_RESULT : psic_pkg::ST_GET_P;
         end
         psic_pkg::ST_GET_P: state_in = psic_pkg::ST_GET_Q;
         psic_pkg::ST_GET_Q: state_in = psic_pkg::ST_GET_R;
         psic_pkg::ST_GET_R: state_in = psic_pkg::ST_GET_S;
         psic_pkg::ST_GET_S: state_in = psic_pkg::ST_TEST;
         psic_pkg::ST_TEST: begin
            if (status.done) begin
               if (status.hit) state_in = psic_pkg::ST_RESULT;
               else if (more_j) state_in = psic_pkg::ST_GET_S;
               else state_in = psic_pkg::ST_OUTER;
            end
         end
         psic_pkg::ST_RESULT: begin
            if (rsp_fire) state_in = psic_pkg::ST_LOAD;
         end
         default: state_in = psic_pkg::ST_LOAD;
      endcase
   end

   // Outputs of the sequencer: store reads, tester start, handshakes.
   always_comb begin
      rd_en      = 1'b0;
      rd_idx     = i_ff;
      test_start = 1'b0;
      unique case (state_ff)
         psic_pkg::ST_OUTER: begin
            rd_en  = !no_pair;
            rd_idx = i_ff;
         end
         psic_pkg::ST_GET_P: begin
            rd_en  = 1'b1;
            rd_idx = i_ff + CW'(1);
         end
         psic_pkg::ST_GET_Q: begin
            rd_en  = 1'b1;
            rd_idx = i_ff + CW'(2);
         end
         psic_pkg::ST_GET_R: begin
            rd_en  = 1'b1;
            rd_idx = i_ff + CW'(3);
         end
         psic_pkg::ST_GET_S: test_start = 1'b1;
         psic_pkg::ST_TEST: begin
            rd_en  = status.done && !status.hit && more_j;
            rd_idx = j_ff + CW'(2);
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = (state_ff == psic_pkg::ST_LOAD);
   assign rsp_chan.valid = (state_ff == psic_pkg::ST_RESULT);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.is_simple      = simple_ff;
   assign rsp_chan.first_segment  = first_ff;
   assign rsp_chan.second_segment = second_ff;
   assign rsp_chan.overflow       = ovf_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psic_pkg::ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         cross_tol_ff <= psic_pkg::CROSS_TOL_RESET;
         coord_tol_ff <= psic_pkg::COORD_TOL_RESET;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            if (count_ff < CW'(MAX_POINTS)) count_ff <= count_ff + CW'(1);
            else ovf_ff <= 1'b1;
         end
         if (rsp_fire) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
         end
         if (csr_fire) begin
            case (csr_chan.reg_index)
               psic_pkg::CSR_CROSS_TOL: cross_tol_ff <= csr_chan.write_data;
               psic_pkg::CSR_COORD_TOL: coord_tol_ff <= csr_chan.write_data[15:0];
               default: ;
            endcase
         end
      end
   end

   // Loop indexes, fetched vertices and the result.
   always_ff @(posedge clock) begin
      case (state_ff)
         psic_pkg::ST_LOAD: begin
            i_ff <= '0;
         end
         psic_pkg::ST_OUTER: begin
            j_ff <= i_ff + CW'(2);
            if (no_pair) begin
               simple_ff <= 1'b1;
               first_ff  <= '0;
               second_ff <= '0;
            end
         end
         psic_pkg::ST_GET_P: p_ff <= rd_vertex;
         psic_pkg::ST_GET_Q: q_ff <= rd_vertex;
         psic_pkg::ST_GET_R: r_ff <= rd_vertex;
         psic_pkg::ST_GET_S: s_ff <= rd_vertex;
         psic_pkg::ST_TEST: begin
            if (status.done) begin
               if (status.hit) begin
                  simple_ff <= 1'b0;
                  first_ff  <= 8'(i_ff);
                  second_ff <= 8'(j_ff);
               end else if (more_j) begin
                  j_ff <= j_ff + CW'(1);
                  r_ff <= s_ff;
               end else begin
                  i_ff <= i_ff + CW'(1);
               end
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire
